FILE: rtl/bpr_pkg.sv
package bpr_pkg;

    // Image geometry and header lengths
    localparam int LINES          = 720;
    localparam int BYTES_PER_LINE = 72;
    localparam int SHORT_HEADER   = 512;
    localparam int EXTRA_HEADER   = 128;

    localparam int IMAGE_TOTAL = LINES * BYTES_PER_LINE;
    localparam int LONG_HEADER = SHORT_HEADER + EXTRA_HEADER;

    // Counter widths
    localparam int POS_W = $clog2(IMAGE_TOTAL + 1);
    localparam int HDR_W = $clog2(LONG_HEADER + 1);
    localparam int CMP_W = POS_W + 8;

    localparam logic [POS_W-1:0] POS_TOTAL = POS_W'(IMAGE_TOTAL);
    localparam logic [HDR_W-1:0] HDR_SHORT = HDR_W'(SHORT_HEADER);
    localparam logic [HDR_W-1:0] HDR_LONG  = HDR_W'(LONG_HEADER);

    // PackBits codes
    localparam logic [7:0] CNT_NOP    = 8'h80;
    localparam logic [8:0] REPEAT_BASE = 9'd257;

    // Status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_HDR   = 2'd1;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_COUNT,
        PH_LITERAL,
        PH_REPEAT,
        PH_DONE,
        PH_STOP
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_file;
        logic       end_of_file;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  run_value;
        logic [7:0]  run_length;
        logic [15:0] run_start;
        logic        image_done;
        logic [1:0]  status;
    } out_item_t;

    // Image position as reported on the result, masked to 16 bits
    function automatic logic [15:0] start_of(input logic [POS_W-1:0] pos);
        logic [POS_W+15:0] wide;
        wide = {16'd0, pos};
        return wide[15:0];
    endfunction

endpackage

FILE: rtl/bitmap_packbits_run_decoder_top.sv
// Bitmap PackBits run decoder.
// Input channel (item_valid / item_stall / item): one raw file byte per
// transaction, with first_of_file restarting the decoder on that byte and
// end_of_file marking the last byte of the stream.
// Output channel (result_valid / result_stall / result): exactly one result
// per input transaction: the decoded byte value, run length (0 when nothing
// is emitted), start position in the image, image_done and sticky status.
// Latency: a result is valid the cycle after its byte is accepted.
// Throughput: one byte per cycle while result_stall is low; the decoder state
// update and the length clip fit between the decoder state and the result register.
// When the receiver stalls, the result register holds its transaction and
// item_stall rises only while a held result is blocked; a new byte is taken
// in the same cycle the held result leaves.
// Reset (rst_n low, asynchronous) empties the result register and returns
// the decoder to the header phase with all counters and status cleared.
module bitmap_packbits_run_decoder_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  bpr_pkg::in_item_t   item,
    output logic                result_valid,
    input  logic                result_stall,
    output bpr_pkg::out_item_t  result
);

    logic               can_load;
    logic               take;
    bpr_pkg::out_item_t dec_result;

    assign item_stall = !can_load;
    assign take       = item_valid && can_load;

    bpr_decode u_decode (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .item   (item),
        .result (dec_result)
    );

    bpr_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take),
        .load_data (dec_result),
        .can_load  (can_load),
        .valid     (result_valid),
        .stall     (result_stall),
        .data      (result)
    );

endmodule

FILE: rtl/bpr_decode.sv
module bpr_decode (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  bpr_pkg::in_item_t   item,
    output bpr_pkg::out_item_t  result
);

    bpr_pkg::phase_t               phase_reg, phase_next;
    logic [bpr_pkg::HDR_W-1:0]     hcnt_reg, hcnt_next;
    logic                          long_reg, long_next;
    logic [7:0]                    pend_reg, pend_next;
    logic [bpr_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic [1:0]                    err_reg, err_next;

    // Effective state after an optional restart
    bpr_pkg::phase_t               cur_phase;
    logic [bpr_pkg::HDR_W-1:0]     cur_hcnt;
    logic                          cur_long;
    logic [7:0]                    cur_pend;
    logic [bpr_pkg::POS_W-1:0]     cur_pos;
    logic [1:0]                    cur_err;

    logic [7:0]                    b;
    logic                          bad_first;
    logic                          hdr_long;
    logic [bpr_pkg::HDR_W-1:0]     hcnt_inc;
    logic                          hdr_end;
    logic                          is_literal;
    logic                          is_repeat;
    logic [7:0]                    want;
    logic [bpr_pkg::CMP_W-1:0]     want_x;
    logic [bpr_pkg::CMP_W-1:0]     remain_x;
    logic [bpr_pkg::CMP_W-1:0]     len_x;
    logic [bpr_pkg::CMP_W-1:0]     sum_x;
    logic [7:0]                    len;
    logic [bpr_pkg::POS_W-1:0]     pos_sum;
    logic                          img_full;
    logic [8:0]                    rep_len;
    bpr_pkg::phase_t               phase_mid;

    assign b = item.data_byte;

    always_comb
    begin
        if (item.first_of_file)
        begin
            cur_phase = bpr_pkg::PH_HEADER;
            cur_hcnt  = '0;
            cur_long  = 1'b0;
            cur_pend  = '0;
            cur_pos   = '0;
            cur_err   = bpr_pkg::STATUS_OK;
        end
        else
        begin
            cur_phase = phase_reg;
            cur_hcnt  = hcnt_reg;
            cur_long  = long_reg;
            cur_pend  = pend_reg;
            cur_pos   = pos_reg;
            cur_err   = err_reg;
        end
    end

    // Header byte handling
    assign bad_first = (cur_hcnt == '0) && (b != 8'd0);
    assign hdr_long  = (cur_hcnt == bpr_pkg::HDR_W'(1)) ? (b != 8'd0) : cur_long;
    assign hcnt_inc  = cur_hcnt + bpr_pkg::HDR_W'(1);
    assign hdr_end   = hcnt_inc >= (hdr_long ? bpr_pkg::HDR_LONG : bpr_pkg::HDR_SHORT);

    // Count byte classes
    assign is_literal = ~b[7];
    assign is_repeat  = b[7] && (b != bpr_pkg::CNT_NOP);
    assign rep_len    = bpr_pkg::REPEAT_BASE - {1'b0, b};

    // Emitted length clipped at the image end
    assign want     = (cur_phase == bpr_pkg::PH_LITERAL) ? 8'd1 : cur_pend;
    assign want_x   = {{bpr_pkg::POS_W{1'b0}}, want};
    assign remain_x = {8'd0, bpr_pkg::POS_TOTAL - cur_pos};
    assign len_x    = (want_x < remain_x) ? want_x : remain_x;
    assign len      = len_x[7:0];
    assign sum_x    = {8'd0, cur_pos} + {{bpr_pkg::POS_W{1'b0}}, len};
    assign pos_sum  = sum_x[bpr_pkg::POS_W-1:0];
    assign img_full = pos_sum >= bpr_pkg::POS_TOTAL;

    // Next phase
    always_comb
    begin
        phase_mid = cur_phase;
        unique case (cur_phase)
            bpr_pkg::PH_HEADER:
            begin
                if (bad_first)
                    phase_mid = bpr_pkg::PH_STOP;
                else if (hdr_end)
                    phase_mid = bpr_pkg::PH_COUNT;
            end
            bpr_pkg::PH_COUNT:
            begin
                if (is_literal)
                    phase_mid = bpr_pkg::PH_LITERAL;
                else if (is_repeat)
                    phase_mid = bpr_pkg::PH_REPEAT;
            end
            bpr_pkg::PH_LITERAL, bpr_pkg::PH_REPEAT:
            begin
                if (img_full)
                    phase_mid = bpr_pkg::PH_DONE;
                else if (cur_phase == bpr_pkg::PH_LITERAL && cur_pend > 8'd1)
                    phase_mid = bpr_pkg::PH_LITERAL;
                else
                    phase_mid = bpr_pkg::PH_COUNT;
            end
            bpr_pkg::PH_DONE, bpr_pkg::PH_STOP:
                phase_mid = cur_phase;
            default:
                phase_mid = bpr_pkg::PH_STOP;
        endcase

        phase_next = phase_mid;
        if (item.end_of_file && phase_mid != bpr_pkg::PH_DONE
            && phase_mid != bpr_pkg::PH_STOP)
            phase_next = bpr_pkg::PH_STOP;
    end

    // Counters, error flag and the result
    always_comb
    begin
        hcnt_next = cur_hcnt;
        long_next = cur_long;
        pend_next = cur_pend;
        pos_next  = cur_pos;
        err_next  = cur_err;

        result.run_value  = 8'd0;
        result.run_length = 8'd0;
        result.run_start  = bpr_pkg::start_of(cur_pos);

        case (cur_phase)
            bpr_pkg::PH_HEADER:
            begin
                if (bad_first)
                    err_next = bpr_pkg::STATUS_BAD_HDR;
                else
                begin
                    hcnt_next = hcnt_inc;
                    long_next = hdr_long;
                end
            end
            bpr_pkg::PH_COUNT:
            begin
                if (is_literal)
                    pend_next = b + 8'd1;
                else if (is_repeat)
                    pend_next = rep_len[7:0];
            end
            bpr_pkg::PH_LITERAL, bpr_pkg::PH_REPEAT:
            begin
                result.run_value  = b;
                result.run_length = len;
                pos_next          = pos_sum;
                if (cur_phase == bpr_pkg::PH_LITERAL && cur_pend > 8'd1 && !img_full)
                    pend_next = cur_pend - 8'd1;
                else
                    pend_next = 8'd0;
            end
            default:
            begin
            end
        endcase

        // Truncated stream
        if (item.end_of_file && phase_mid != bpr_pkg::PH_DONE
            && phase_mid != bpr_pkg::PH_STOP && err_next == bpr_pkg::STATUS_OK)
            err_next = bpr_pkg::STATUS_TRUNCATED;

        result.image_done = (phase_next == bpr_pkg::PH_DONE);
        result.status     = err_next;
    end

    // Decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= bpr_pkg::PH_HEADER;
            hcnt_reg  <= '0;
            long_reg  <= 1'b0;
            pend_reg  <= '0;
            pos_reg   <= '0;
            err_reg   <= bpr_pkg::STATUS_OK;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            hcnt_reg  <= hcnt_next;
            long_reg  <= long_next;
            pend_reg  <= pend_next;
            pos_reg   <= pos_next;
            err_reg   <= err_next;
        end
    end

endmodule

FILE: rtl/bpr_out_reg.sv
module bpr_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  bpr_pkg::out_item_t  load_data,
    output logic                can_load,
    output logic                valid,
    input  logic                stall,
    output bpr_pkg::out_item_t  data
);

    logic               valid_reg, valid_next;
    bpr_pkg::out_item_t data_reg;

    // Room when empty or when the held transaction leaves this cycle
    assign can_load = !valid_reg || !stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (valid_reg && !stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

FILE: rtl/bpr_checker.sv
module bpr_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_stall,
    input bpr_pkg::in_item_t   item,
    input logic                result_valid,
    input logic                result_stall,
    input bpr_pkg::out_item_t  result
);

    // A stalled result transaction stays and holds its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // Input is only held back by a blocked result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("input stalled without a blocked result");

    // Every accepted byte gives a result next cycle
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> result_valid)
        else $error("accepted byte produced no result");

    // No invented results
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !(item_valid && !item_stall) |=> !result_valid)
        else $error("result without an accepted byte");

    // A nonzero first file byte reports a bad header
    a_bad_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && item.first_of_file && item.data_byte != 8'd0
        |=> result.status == bpr_pkg::STATUS_BAD_HDR && result.run_length == 8'd0)
        else $error("bad header not reported");

endmodule

bind bitmap_packbits_run_decoder_top bpr_checker u_bpr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;

    // PackBits packet forms used by the stream builder
    typedef enum {PK_LIT, PK_REP, PK_NOP} pkt_kind_t;

    // Receiver stall behaviors
    typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

    // Queued input byte; wait_drain holds it back until all results are in
    typedef struct {
        bpr_pkg::in_item_t item;
        bit                wait_drain;
    } feed_t;

    localparam int QUIET_LIMIT = 2000;
    localparam int NOISE_ITEMS = 40;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               item_valid = 1'b0;
    logic               item_stall;
    bpr_pkg::in_item_t  item = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    bpr_pkg::out_item_t result;

    feed_t              byte_q[$];
    bpr_pkg::out_item_t run_expect_q[$];

    // Decoder shadow state
    bpr_pkg::phase_t dec_phase = bpr_pkg::PH_HEADER;
    int unsigned     hdr_seen = 0;
    bit              hdr_long = 1'b0;
    int unsigned     run_left = 0;
    int unsigned     fill_pos = 0;
    logic [1:0]      err_code = bpr_pkg::STATUS_OK;

    // Stream builder bookkeeping
    int unsigned gen_cnt = 0;
    int unsigned gen_fill = 0;
    bit          drain_next = 1'b0;

    // Run statistics
    int unsigned err_cnt = 0;
    int unsigned bytes_in = 0;
    int unsigned results_in = 0;
    int unsigned run_cnt = 0;
    int unsigned done_cnt = 0;
    int unsigned trunc_cnt = 0;
    int unsigned bad_cnt = 0;

    // Traffic shaping
    logic        in_fire = 1'b0;
    int unsigned quiet_cycles = 0;
    int unsigned gap_left = 0;
    int unsigned burst_left = 0;
    int unsigned stall_left = 0;
    int unsigned rx_tick = 0;
    rx_mode_t    rx_mode = RX_OPEN;

    bitmap_packbits_run_decoder_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advance the shadow decoder by one byte and return the run it reports
    function automatic bpr_pkg::out_item_t decode_byte(input bpr_pkg::in_item_t it);
        bpr_pkg::out_item_t r;
        int unsigned        want;
        int unsigned        room;
        int unsigned        hdr_len;
        int unsigned        len;
        r = '0;
        len = 0;
        if (it.first_of_file)
        begin
            dec_phase = bpr_pkg::PH_HEADER;
            hdr_seen  = 0;
            hdr_long  = 1'b0;
            run_left  = 0;
            fill_pos  = 0;
            err_code  = bpr_pkg::STATUS_OK;
        end
        r.run_start = fill_pos[15:0];
        case (dec_phase)
            bpr_pkg::PH_HEADER:
            begin
                if (hdr_seen == 0 && it.data_byte != 8'h00)
                begin
                    err_code  = bpr_pkg::STATUS_BAD_HDR;
                    dec_phase = bpr_pkg::PH_STOP;
                    bad_cnt++;
                end
                else
                begin
                    if (hdr_seen == 1)
                        hdr_long = (it.data_byte != 8'h00);
                    hdr_seen++;
                    hdr_len = bpr_pkg::SHORT_HEADER + (hdr_long ? bpr_pkg::EXTRA_HEADER : 0);
                    if (hdr_seen >= hdr_len)
                        dec_phase = bpr_pkg::PH_COUNT;
                end
            end
            bpr_pkg::PH_COUNT:
            begin
                if (it.data_byte < bpr_pkg::CNT_NOP)
                begin
                    run_left  = it.data_byte + 1;
                    dec_phase = bpr_pkg::PH_LITERAL;
                end
                else if (it.data_byte > bpr_pkg::CNT_NOP)
                begin
                    run_left  = int'(bpr_pkg::REPEAT_BASE) - int'(it.data_byte);
                    dec_phase = bpr_pkg::PH_REPEAT;
                end
            end
            bpr_pkg::PH_LITERAL, bpr_pkg::PH_REPEAT:
            begin
                want = (dec_phase == bpr_pkg::PH_LITERAL) ? 1 : run_left;
                room = bpr_pkg::IMAGE_TOTAL - fill_pos;
                len  = (want < room) ? want : room;
                r.run_value = it.data_byte;
                fill_pos += len;
                if (dec_phase == bpr_pkg::PH_LITERAL && run_left > 1)
                    run_left--;
                else
                begin
                    run_left  = 0;
                    dec_phase = bpr_pkg::PH_COUNT;
                end
                if (fill_pos >= bpr_pkg::IMAGE_TOTAL)
                begin
                    run_left  = 0;
                    dec_phase = bpr_pkg::PH_DONE;
                    done_cnt++;
                end
            end
            default: ;
        endcase
        // end of stream before the image is complete
        if (it.end_of_file && dec_phase != bpr_pkg::PH_DONE && dec_phase != bpr_pkg::PH_STOP)
        begin
            if (err_code == bpr_pkg::STATUS_OK)
            begin
                err_code = bpr_pkg::STATUS_TRUNCATED;
                trunc_cnt++;
            end
            dec_phase = bpr_pkg::PH_STOP;
        end
        r.run_length = len[7:0];
        r.image_done = (dec_phase == bpr_pkg::PH_DONE);
        r.status     = err_code;
        return r;
    endfunction

    // Queue one raw byte for the sender
    task automatic put(input logic [7:0] b, input bit first = 1'b0, input bit last = 1'b0);
        feed_t f;
        f.item.data_byte     = b;
        f.item.first_of_file = first;
        f.item.end_of_file   = last;
        f.wait_drain         = drain_next;
        drain_next           = 1'b0;
        byte_q.push_back(f);
        gen_cnt++;
    endtask

    // Full file header; a nonzero select byte asks for the long form
    task automatic put_header(input logic [7:0] hdr_sel);
        int hdr_len;
        hdr_len = (hdr_sel != 8'h00) ? bpr_pkg::LONG_HEADER : bpr_pkg::SHORT_HEADER;
        put(8'h00, 1'b1);
        put(hdr_sel);
        repeat (hdr_len - 2) put(8'($urandom));
        gen_fill = 0;
    endtask

    // One PackBits packet of n image bytes; val leads a literal or is the repeated byte
    task automatic put_packet(input pkt_kind_t kind, input int n, input logic [7:0] val);
        case (kind)
            PK_LIT:
            begin
                put(8'(n - 1));
                put(val);
                repeat (n - 1) put(8'($urandom));
                gen_fill += n;
            end
            PK_REP:
            begin
                put(8'(int'(bpr_pkg::REPEAT_BASE) - n));
                put(val);
                gen_fill += n;
            end
            default: put(bpr_pkg::CNT_NOP);
        endcase
    endtask

    // Sender and receiver, driven on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            // sender: bursts of transactions separated by idle gaps
            if (!item_valid || in_fire)
            begin
                if (gap_left != 0)
                begin
                    item_valid <= 1'b0;
                    gap_left--;
                end
                else if (byte_q.size() != 0 &&
                         !(byte_q[0].wait_drain && run_expect_q.size() != 0))
                begin
                    item       <= byte_q[0].item;
                    item_valid <= 1'b1;
                    void'(byte_q.pop_front());
                    if (burst_left <= 1)
                    begin
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                                  : $urandom_range(1, 24);
                        gap_left   = $urandom_range(1, 7);
                    end
                    else
                        burst_left--;
                end
                else
                    item_valid <= 1'b0;
            end

            // receiver: stall pattern changes whenever its hold counter runs out
            if (stall_left == 0)
            begin
                rx_mode    = rx_mode_t'($urandom_range(0, 3));
                stall_left = $urandom_range(20, 300);
            end
            else
                stall_left--;
            rx_tick++;
            case (rx_mode)
                RX_OPEN:   result_stall <= 1'b0;
                RX_LIGHT:  result_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY:  result_stall <= ($urandom_range(0, 9) < 7);
                default:   result_stall <= ((rx_tick % 5) < 2);
            endcase
        end
    end

    // Check results, predict accepted bytes, and watch for a hang
    always @(posedge clk or negedge rst_n)
    begin : result_check
        bpr_pkg::out_item_t exp_run;
        if (!rst_n)
        begin
            in_fire      <= 1'b0;
            quiet_cycles <= 0;
        end
        else
        begin
            in_fire <= item_valid && !item_stall;

            if (result_valid && !result_stall)
            begin
                results_in++;
                if (run_expect_q.size() == 0)
                begin
                    if (err_cnt < 10)
                    begin
                        $write("tb: unexpected result val=%02h len=%0d start=%0d",
                               result.run_value, result.run_length, result.run_start);
                        $display(" done=%0b st=%0d", result.image_done, result.status);
                    end
                    err_cnt++;
                end
                else
                begin
                    exp_run = run_expect_q.pop_front();
                    if (exp_run.run_length != 0)
                        run_cnt++;
                    if (result.run_value !== exp_run.run_value ||
                        result.run_length !== exp_run.run_length ||
                        result.run_start !== exp_run.run_start ||
                        result.image_done !== exp_run.image_done ||
                        result.status !== exp_run.status)
                    begin
                        if (err_cnt < 10)
                        begin
                            $write("tb: result %0d mismatch: exp val=%02h len=%0d start=%0d",
                                   results_in, exp_run.run_value, exp_run.run_length,
                                   exp_run.run_start);
                            $write(" done=%0b st=%0d", exp_run.image_done, exp_run.status);
                            $display(" | got val=%02h len=%0d start=%0d done=%0b st=%0d",
                                     result.run_value, result.run_length, result.run_start,
                                     result.image_done, result.status);
                        end
                        err_cnt++;
                    end
                end
            end

            if (item_valid && !item_stall)
            begin
                bytes_in++;
                run_expect_q.push_back(decode_byte(item));
            end

            // watchdog on cycles with no transaction on either side
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb: stuck for %0d cycles, %0d results outstanding",
                         quiet_cycles, run_expect_q.size());
                $display("tb: done, errors");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stream contents, reset, and end of run
    initial
    begin
        int unsigned noise_goal;
        int unsigned pick;

        // bad header: nonzero first byte, rest ignored, end of stream keeps the status
        put(8'hFF, 1'b1);
        put(8'h00);
        put(8'h7F, 1'b0, 1'b1);
        put(8'h01, 1'b1);
        put(8'hFF);
        // whole stream in one byte: truncated inside the header
        put(8'h00, 1'b1, 1'b1);

        // long header, every packet form, stream ends inside a literal
        put_header(8'hFF);
        put_packet(PK_LIT, 1, 8'h00);
        put_packet(PK_LIT, 128, 8'hFF);
        put_packet(PK_NOP, 0, 8'h00);
        put_packet(PK_REP, 2, 8'hFF);
        put_packet(PK_REP, 128, 8'h00);
        put(8'h02);
        put(8'hA5);
        put(8'h5A, 1'b0, 1'b1);
        put(8'h11, 1'b0, 1'b1);

        // line noise: stray bytes, bad headers and headers cut short
        noise_goal = gen_cnt + NOISE_ITEMS;
        while (gen_cnt < noise_goal)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                repeat ($urandom_range(1, 6))
                    put(8'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
            end
            else if (pick < 70)
            begin
                put(8'($urandom_range(1, 255)), 1'b1);
                repeat ($urandom_range(0, 4)) put(8'($urandom));
                put(8'($urandom), 1'b0, $urandom_range(0, 1));
            end
            else
            begin
                put(8'h00, 1'b1);
                repeat ($urandom_range(0, 12)) put(8'($urandom));
                put(8'($urandom), 1'b0, 1'b1);
            end
        end

        // short header file that fills the image, sent once every earlier result is back
        drain_next = 1'b1;
        put_header(8'h00);
        while (gen_fill < bpr_pkg::IMAGE_TOTAL)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 92)
                put_packet(PK_REP, $urandom_range(120, 128), 8'($urandom));
            else if (pick < 97)
                put_packet(PK_LIT, $urandom_range(1, 6), 8'($urandom));
            else
                put_packet(PK_NOP, 0, 8'h00);
        end
        // trailing bytes after completion are ignored, end of stream included
        repeat ($urandom_range(1, 5)) put(8'($urandom));
        put(8'($urandom), 1'b0, 1'b1);

        // reset held low at the start, released on a falling edge
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // wait for the stream to drain, then give stray results time to appear
        @(negedge clk);
        while (byte_q.size() != 0 || item_valid || run_expect_q.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);

        $display("tb: %0d bytes in, %0d results checked, %0d nonempty runs",
                 bytes_in, results_in, run_cnt);
        $display("tb: %0d images completed, %0d streams truncated, %0d bad headers",
                 done_cnt, trunc_cnt, bad_cnt);
        if (err_cnt == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
rtl/bpr_pkg.sv
rtl/bpr_decode.sv
rtl/bpr_out_reg.sv
rtl/bitmap_packbits_run_decoder_top.sv
rtl/bpr_checker.sv
test/tb.sv
